// ===== src/pending_request_timeout_tracker_assert.svh =====
// assertion macros for the request tracker
`ifndef PENDING_REQUEST_TIMEOUT_TRACKER_ASSERT_SVH
`define PENDING_REQUEST_TIMEOUT_TRACKER_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define PRTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request tracker check failed");

// next-cycle implication, clocked on clk, held off during reset
`define PRTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("request tracker check failed");

`endif

// ===== src/prtt_pkg.sv =====
package prtt_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int SEQ_BITS_DEF = 16;

    localparam int REQ_W     = 2;
    localparam int IN_SEQ_W  = 16;
    localparam int CODE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int OUT_SEQ_W = 16;
    localparam int AGE_W     = 6;

    localparam logic [AGE_W-1:0] AGE_MAX     = 6'd63;
    localparam logic [AGE_W-1:0] TIMEOUT_RST = 6'd40;

    typedef enum logic [REQ_W-1:0] {
        REQ_ISSUE = 2'd0,
        REQ_RESP  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ISSUED   = 3'd0,
        KIND_ANSWERED = 3'd1,
        KIND_TIMEOUT  = 3'd2,
        KIND_UNKNOWN  = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_NOTHING  = 3'd5
    } kind_t;

endpackage

// ===== src/prtt_ram.sv =====
module prtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pending_request_timeout_tracker.sv =====
// outstanding request tracker with timeout
// command channel: drive req_type, resp_seq and resp_code with start; the
// transaction is taken on a clock edge where start is high and busy is low.
// issue (0) allocates the lowest free slot with the next sequence number,
// response (1) looks up a pending slot by sequence, tick (2) ages all pending slots
// and retires those that reach timeout_ticks; req_type 3 is taken and dropped.
// every issue, response or tick is handled by one slot scan: a single comparator and age
// incrementer walk the slot memory one slot per cycle, with a registered read.
// issue and response stop at the first hit or at the last slot, a tick
// walks every slot and then flushes its final result; busy stays high meanwhile.
// results appear on result_kind, sequence_res, code_out and last, each for a
// single cycle marked by result_valid; the receiver cannot stall and every
// result must be taken in its cycle. a tick gives one result per expired
// slot in slot order, or one "nothing expired" result; last marks the final.
// timeout_ticks is written through cfg_valid/cfg_ready/cfg_data while idle.
// reset clears all slot valid marks, the sequence counter and sets the
// timeout to 40; the slot memory itself needs no clearing.
`include "pending_request_timeout_tracker_assert.svh"

module pending_request_timeout_tracker #(
    parameter int SLOTS    = prtt_pkg::SLOTS_DEF,
    parameter int SEQ_BITS = prtt_pkg::SEQ_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [prtt_pkg::REQ_W-1:0]       req_type,
    input  logic [prtt_pkg::IN_SEQ_W-1:0]    resp_seq,
    input  logic [prtt_pkg::CODE_W-1:0]      resp_code,
    output logic                             result_valid,
    output logic [prtt_pkg::KIND_W-1:0]      result_kind,
    output logic [prtt_pkg::OUT_SEQ_W-1:0]   sequence_res,
    output logic [prtt_pkg::CODE_W-1:0]      code_out,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prtt_pkg::AGE_W-1:0]       cfg_data
);

    import prtt_pkg::*;

    localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int RAM_W = SEQ_BITS + AGE_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic [SEQ_BITS-1:0]    next_seq_reg, next_seq_next;
    logic [AGE_W-1:0]       timeout_reg, timeout_next;
    logic [REQ_W-1:0]       op_reg, op_next;
    logic [IN_SEQ_W-1:0]    rseq_reg, rseq_next;
    logic [CODE_W-1:0]      rcode_reg, rcode_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   rd_run_reg, rd_run_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   hold_vld_reg, hold_vld_next;
    logic [OUT_SEQ_W-1:0]   hold_seq_reg, hold_seq_next;
    logic                   strobe_reg, strobe_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [OUT_SEQ_W-1:0]   oseq_reg, oseq_next;
    logic [CODE_W-1:0]      ocode_reg, ocode_next;
    logic                   olast_reg, olast_next;

    logic                   ram_we;
    logic                   ram_re;
    logic [RAM_W-1:0]       ram_wdata;
    logic [RAM_W-1:0]       ram_rdata;

    logic [SEQ_BITS-1:0]    cur_seq;
    logic [AGE_W-1:0]       cur_age;
    logic [AGE_W-1:0]       aged;
    logic                   cur_valid;
    logic                   at_end;

    prtt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chk_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign cur_seq   = ram_rdata[RAM_W-1:AGE_W];
    assign cur_age   = ram_rdata[AGE_W-1:0];
    assign aged      = (cur_age == AGE_MAX) ? cur_age : cur_age + AGE_W'(1);
    assign cur_valid = valid_reg[chk_idx_reg];
    assign at_end    = (chk_idx_reg == IDX_LAST);

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        next_seq_next = next_seq_reg;
        timeout_next  = timeout_reg;
        op_next       = op_reg;
        rseq_next     = rseq_reg;
        rcode_next    = rcode_reg;
        rd_idx_next   = rd_idx_reg;
        rd_run_next   = rd_run_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = 1'b0;
        hold_vld_next = hold_vld_reg;
        hold_seq_next = hold_seq_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        oseq_next     = oseq_reg;
        ocode_next    = ocode_reg;
        olast_next    = olast_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_wdata     = {next_seq_reg, AGE_W'(0)};

        if (cfg_valid && cfg_ready)
        begin
            timeout_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = req_type;
                    rseq_next  = resp_seq;
                    rcode_next = resp_code;
                    if (req_type != REQ_NONE)
                    begin
                        state_next    = ST_SCAN;
                        rd_idx_next   = '0;
                        rd_run_next   = 1'b1;
                        hold_vld_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                // read side of the scan
                if (rd_run_reg)
                begin
                    ram_re       = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg;
                    if (rd_idx_reg == IDX_LAST)
                    begin
                        rd_run_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
                // check side of the scan
                if (chk_vld_reg)
                begin
                    case (op_reg)
                        REQ_ISSUE:
                        begin
                            if (!cur_valid)
                            begin
                                valid_next[chk_idx_reg] = 1'b1;
                                ram_we        = 1'b1;
                                ram_wdata     = {next_seq_reg, AGE_W'(0)};
                                next_seq_next = next_seq_reg + SEQ_BITS'(1);
                                strobe_next   = 1'b1;
                                kind_next     = KIND_ISSUED;
                                oseq_next     = OUT_SEQ_W'(next_seq_reg);
                                ocode_next    = '0;
                                olast_next    = 1'b1;
                                state_next    = ST_IDLE;
                            end
                            else if (at_end)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_FULL;
                                oseq_next   = '0;
                                ocode_next  = '0;
                                olast_next  = 1'b1;
                                state_next  = ST_IDLE;
                            end
                        end
                        REQ_RESP:
                        begin
                            if (cur_valid && (cur_seq == SEQ_BITS'(rseq_reg)))
                            begin
                                valid_next[chk_idx_reg] = 1'b0;
                                strobe_next = 1'b1;
                                kind_next   = KIND_ANSWERED;
                                oseq_next   = rseq_reg;
                                ocode_next  = rcode_reg;
                                olast_next  = 1'b1;
                                state_next  = ST_IDLE;
                            end
                            else if (at_end)
                            begin
                                strobe_next = 1'b1;
                                kind_next   = KIND_UNKNOWN;
                                oseq_next   = rseq_reg;
                                ocode_next  = '0;
                                olast_next  = 1'b1;
                                state_next  = ST_IDLE;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (cur_valid)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {cur_seq, aged};
                                if (aged >= timeout_reg)
                                begin
                                    valid_next[chk_idx_reg] = 1'b0;
                                    // earlier expiry goes out now, newest is held back
                                    if (hold_vld_reg)
                                    begin
                                        strobe_next = 1'b1;
                                        kind_next   = KIND_TIMEOUT;
                                        oseq_next   = hold_seq_reg;
                                        ocode_next  = '0;
                                        olast_next  = 1'b0;
                                    end
                                    hold_vld_next = 1'b1;
                                    hold_seq_next = OUT_SEQ_W'(cur_seq);
                                end
                            end
                            if (at_end)
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                strobe_next = 1'b1;
                kind_next   = hold_vld_reg ? KIND_TIMEOUT : KIND_NOTHING;
                oseq_next   = hold_vld_reg ? hold_seq_reg : '0;
                ocode_next  = '0;
                olast_next  = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            next_seq_reg <= '0;
            timeout_reg  <= TIMEOUT_RST;
            op_reg       <= REQ_NONE;
            rseq_reg     <= '0;
            rcode_reg    <= '0;
            rd_idx_reg   <= '0;
            rd_run_reg   <= 1'b0;
            chk_idx_reg  <= '0;
            chk_vld_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
            hold_seq_reg <= '0;
            strobe_reg   <= 1'b0;
            kind_reg     <= KIND_NOTHING;
            oseq_reg     <= '0;
            ocode_reg    <= '0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            next_seq_reg <= next_seq_next;
            timeout_reg  <= timeout_next;
            op_reg       <= op_next;
            rseq_reg     <= rseq_next;
            rcode_reg    <= rcode_next;
            rd_idx_reg   <= rd_idx_next;
            rd_run_reg   <= rd_run_next;
            chk_idx_reg  <= chk_idx_next;
            chk_vld_reg  <= chk_vld_next;
            hold_vld_reg <= hold_vld_next;
            hold_seq_reg <= hold_seq_next;
            strobe_reg   <= strobe_next;
            kind_reg     <= kind_next;
            oseq_reg     <= oseq_next;
            ocode_reg    <= ocode_next;
            olast_reg    <= olast_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign result_valid = strobe_reg;
    assign result_kind  = kind_reg;
    assign sequence_res = oseq_reg;
    assign code_out     = ocode_reg;
    assign last         = olast_reg;

    // a real command always starts a scan
    `PRTT_ASSERT_NEXT(a_start_scans, start && !busy && (req_type != REQ_NONE), busy)
    // the final result of a transaction leaves the block idle
    `PRTT_ASSERT_NOW(a_last_idle, result_valid && last, !busy)
    // only timeouts can be followed by further results
    `PRTT_ASSERT_NOW(a_more_only_timeout, result_valid && !last, result_kind == KIND_TIMEOUT)
    // a non-final result always has a successor in the next cycles of the scan
    `PRTT_ASSERT_NOW(a_more_while_busy, result_valid && !last, busy)

endmodule

// ===== tb/tb_pending_request_timeout_tracker.sv =====
`timescale 1ns / 1ps

module tb_pending_request_timeout_tracker;

    import prtt_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int DRAIN_CYCLES = SLOTS + 8;

    typedef struct packed {
        kind_t                 kind;
        logic [OUT_SEQ_W-1:0]  seq;
        logic [CODE_W-1:0]     code;
        logic                  last;
    } res_t;

    typedef struct packed {
        bit                    wr;
        logic [AGE_W-1:0]      tmo;
        req_t                  op;
        logic [IN_SEQ_W-1:0]   seq;
        logic [CODE_W-1:0]     code;
        int                    reps;
        bit                    typed;
        kind_t                 exp_kind;
        logic [OUT_SEQ_W-1:0]  exp_seq;
        logic [CODE_W-1:0]     exp_code;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      req_type;
    logic [IN_SEQ_W-1:0]   resp_seq;
    logic [CODE_W-1:0]     resp_code;
    logic                  result_valid;
    logic [KIND_W-1:0]     result_kind;
    logic [OUT_SEQ_W-1:0]  sequence_res;
    logic [CODE_W-1:0]     code_out;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [AGE_W-1:0]      cfg_data;

    // shadow of the slot table
    bit                    sh_valid [SLOTS];
    logic [OUT_SEQ_W-1:0]  sh_seq   [SLOTS];
    logic [AGE_W-1:0]      sh_age   [SLOTS];
    logic [OUT_SEQ_W-1:0]  sh_next;
    logic [AGE_W-1:0]      sh_timeout;

    res_t                  step_buf [SLOTS];
    int                    step_n;
    res_t                  due_results [$];
    row_t                  dir_rows [$];
    int                    errors;

    pending_request_timeout_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .resp_seq     (resp_seq),
        .resp_code    (resp_code),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .sequence_res (sequence_res),
        .code_out     (code_out),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic res_t make_res(input kind_t k, input logic [OUT_SEQ_W-1:0] s,
                                      input logic [CODE_W-1:0] c);
        res_t r;
        r.kind = k;
        r.seq  = s;
        r.code = c;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic track_command(input req_t op, input logic [IN_SEQ_W-1:0] s,
                                 input logic [CODE_W-1:0] c);
        int i;
        int hit;
        hit    = -1;
        step_n = 0;
        case (op)
            REQ_ISSUE:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (!sh_valid[i] && hit < 0)
                        hit = i;
                if (hit < 0)
                    step_buf[0] = make_res(KIND_FULL, '0, '0);
                else
                begin
                    sh_valid[hit] = 1'b1;
                    sh_seq[hit]   = sh_next;
                    sh_age[hit]   = '0;
                    step_buf[0]   = make_res(KIND_ISSUED, sh_next, '0);
                    sh_next       = sh_next + 1'b1;
                end
                step_n = 1;
            end
            REQ_RESP:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (sh_valid[i] && sh_seq[i] == s && hit < 0)
                        hit = i;
                if (hit < 0)
                    step_buf[0] = make_res(KIND_UNKNOWN, s, '0);
                else
                begin
                    sh_valid[hit] = 1'b0;
                    step_buf[0]   = make_res(KIND_ANSWERED, s, c);
                end
                step_n = 1;
            end
            REQ_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (sh_valid[i])
                    begin
                        if (sh_age[i] < AGE_MAX)
                            sh_age[i] = sh_age[i] + 1'b1;
                        if (sh_age[i] >= sh_timeout)
                        begin
                            sh_valid[i]      = 1'b0;
                            step_buf[step_n] = make_res(KIND_TIMEOUT, sh_seq[i], '0);
                            step_n++;
                        end
                    end
                end
                if (step_n == 0)
                begin
                    step_buf[0] = make_res(KIND_NOTHING, '0, '0);
                    step_n      = 1;
                end
            end
            default:
                step_n = 0;
        endcase
        if (step_n > 0)
            step_buf[step_n-1].last = 1'b1;
    endtask

    function automatic logic [IN_SEQ_W-1:0] pick_pending(input logic [IN_SEQ_W-1:0] fallback);
        int i;
        int n;
        int j;
        n = 0;
        for (i = 0; i < SLOTS; i++)
            if (sh_valid[i])
                n++;
        if (n == 0)
            return fallback;
        j = $urandom_range(0, n - 1);
        for (i = 0; i < SLOTS; i++)
        begin
            if (sh_valid[i])
            begin
                if (j == 0)
                    return sh_seq[i];
                j--;
            end
        end
        return fallback;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic run_command(input req_t op, input logic [IN_SEQ_W-1:0] s,
                               input logic [CODE_W-1:0] c, input int gap,
                               input bit typed, input res_t want);
        int i;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        req_type  <= op;
        resp_seq  <= s;
        resp_code <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        track_command(op, s, c);
        if (typed)
            due_results.push_back(want);
        else
            for (i = 0; i < step_n; i++)
                due_results.push_back(step_buf[i]);
        @(negedge clk);
    endtask

    task automatic drain_results;
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_timeout(input logic [AGE_W-1:0] v);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sh_timeout = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input bit wr, input logic [AGE_W-1:0] tmo, input req_t op,
                           input logic [IN_SEQ_W-1:0] s, input logic [CODE_W-1:0] c,
                           input int reps, input bit typed, input kind_t k,
                           input logic [OUT_SEQ_W-1:0] es, input logic [CODE_W-1:0] ec);
        row_t rw;
        rw.wr       = wr;
        rw.tmo      = tmo;
        rw.op       = op;
        rw.seq      = s;
        rw.code     = c;
        rw.reps     = reps;
        rw.typed    = typed;
        rw.exp_kind = k;
        rw.exp_seq  = es;
        rw.exp_code = ec;
        dir_rows.push_back(rw);
    endtask

    always @(posedge clk)
    begin : check_results
        res_t w;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t unexpected result: kind %0d seq %h code %h last %b", $time,
                         result_kind, sequence_res, code_out, last);
                errors++;
            end
            else
            begin
                w = due_results.pop_front();
                if (result_kind !== w.kind || sequence_res !== w.seq ||
                    code_out !== w.code || last !== w.last)
                begin
                    $display("%0t mismatch: expected %0d/%h/%h/%b, actual %0d/%h/%h/%b",
                             $time, w.kind, w.seq, w.code, w.last,
                             result_kind, sequence_res, code_out, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        row_t                 rw;
        res_t                 want;
        res_t                 none;
        int                   k;
        int                   i;
        int                   ph;
        int                   r;
        bit                   quiet;
        req_t                 op;
        logic [IN_SEQ_W-1:0]  s;
        logic [CODE_W-1:0]    c;

        errors     = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_NONE;
        resp_seq   = '0;
        resp_code  = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        none       = make_res(KIND_ISSUED, '0, '0);
        sh_next    = '0;
        sh_timeout = TIMEOUT_RST;
        for (i = 0; i < SLOTS; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_seq[i]   = '0;
            sh_age[i]   = '0;
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_row(0, 0,  REQ_TICK,  16'h0000, 8'h00, 1,  1, KIND_NOTHING,  16'h0000, 8'h00);
        add_row(0, 0,  REQ_RESP,  16'hFFFF, 8'hFF, 1,  1, KIND_UNKNOWN,  16'hFFFF, 8'h00);
        add_row(0, 0,  REQ_ISSUE, 16'hFFFF, 8'hFF, 1,  1, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_RESP,  16'h0000, 8'hA5, 1,  1, KIND_ANSWERED, 16'h0000, 8'hA5);
        add_row(0, 0,  REQ_NONE,  16'h1234, 8'h5A, 1,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_ISSUE, 16'h0000, 8'h00, 16, 0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_ISSUE, 16'h0000, 8'h00, 1,  1, KIND_FULL,     16'h0000, 8'h00);
        add_row(0, 0,  REQ_RESP,  16'd16,   8'hFF, 1,  1, KIND_ANSWERED, 16'd16,   8'hFF);
        add_row(0, 0,  REQ_RESP,  16'd16,   8'h01, 1,  1, KIND_UNKNOWN,  16'd16,   8'h00);
        add_row(0, 0,  REQ_TICK,  16'h0000, 8'h00, 1,  1, KIND_NOTHING,  16'h0000, 8'h00);
        add_row(1, 1,  REQ_NONE,  16'h0000, 8'h00, 0,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_TICK,  16'h0000, 8'h00, 1,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_TICK,  16'h0000, 8'h00, 1,  1, KIND_NOTHING,  16'h0000, 8'h00);
        add_row(1, 0,  REQ_NONE,  16'h0000, 8'h00, 0,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_ISSUE, 16'h0000, 8'h00, 2,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_TICK,  16'h0000, 8'h00, 1,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(1, 63, REQ_NONE,  16'h0000, 8'h00, 0,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_ISSUE, 16'h0000, 8'h00, 3,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_TICK,  16'h0000, 8'h00, 2,  0, KIND_ISSUED,   16'h0000, 8'h00);
        add_row(0, 0,  REQ_RESP,  16'd20,   8'h3C, 1,  1, KIND_ANSWERED, 16'd20,   8'h3C);

        for (k = 0; k < dir_rows.size(); k++)
        begin
            rw   = dir_rows[k];
            want = make_res(rw.exp_kind, rw.exp_seq, rw.exp_code);
            want.last = 1'b1;
            if (rw.wr)
                set_timeout(rw.tmo);
            else
                for (i = 0; i < rw.reps; i++)
                    run_command(rw.op, rw.seq, rw.code, $urandom_range(0, 8), rw.typed, want);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_timeout(AGE_W'($urandom_range(2, 8)));
                1:       set_timeout(AGE_W'(1));
                2:       set_timeout(AGE_W'($urandom_range(9, 24)));
                default: set_timeout(AGE_W'(63));
            endcase
            quiet = 1'b0;
            for (k = 0; k < 86; k++)
            begin
                if (k % 16 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 29) == 0)
                    drain_results();
                r = $urandom_range(0, 99);
                s = IN_SEQ_W'($urandom_range(0, 65535));
                c = CODE_W'($urandom_range(0, 255));
                if (r < 35)
                    op = REQ_ISSUE;
                else if (r < 70)
                begin
                    op = REQ_RESP;
                    if ($urandom_range(0, 4) != 0)
                        s = pick_pending(s);
                end
                else if (r < 95)
                    op = REQ_TICK;
                else
                    op = REQ_NONE;
                run_command(op, s, c, quiet ? 0 : $urandom_range(0, 8), 0, none);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && due_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
